// File: src/kvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared types, codes and field widths of the knot vector span engine.
// ----------------------------------------------------------------------------
package kvs_pkg;

    localparam int KVS_DEPTH_DEF = 256;
    localparam int KNOT_W        = 32;
    localparam int TOL_W         = 16;
    localparam int ORDER_W       = 9;
    localparam int POS_W         = 8;
    localparam int MULT_W        = 9;
    localparam int COUNT_W       = 9;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int CMP_W         = KNOT_W + 2;
    localparam int SEARCH_LIMIT  = 32;
    localparam int STEP_W        = $clog2(SEARCH_LIMIT + 1);

    localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd1;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 9'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOL   = 1'b0,
        CFG_ORDER = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_SPAN   = 2'd2,
        ACT_MULT   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_ORDER   = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_ORD_INV = 3'd3,
        STAT_DOMAIN  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SPAN_LO,
        ST_SPAN_HI,
        ST_SPAN_LAST,
        ST_BIS_M,
        ST_BIS_M1,
        ST_MULT_FIND,
        ST_MULT_RUN,
        ST_RESP
    } t_state;

endpackage
`default_nettype wire

// File: src/kvs_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvs_in_if
// Request channel: one action and its value per word.
// ----------------------------------------------------------------------------
interface kvs_in_if import kvs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_action                  action;
    logic signed [KNOT_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

// File: src/kvs_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvs_out_if
// Result channel: status, span and multiplicity per word.
// ----------------------------------------------------------------------------
interface kvs_out_if import kvs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic [POS_W-1:0]         position;
    logic signed [KNOT_W-1:0] span_low;
    logic signed [KNOT_W-1:0] span_high;
    logic [MULT_W-1:0]        multiplicity;
    logic [COUNT_W-1:0]       knot_count;

    modport source (output valid, output status, output position, output span_low,
                    output span_high, output multiplicity, output knot_count,
                    input ready);
    modport sink   (input valid, input status, input position, input span_low,
                    input span_high, input multiplicity, input knot_count,
                    output ready);
endinterface
`default_nettype wire

// File: src/kvs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvs_ram
// Knot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kvs_ram import kvs_pkg::*; #(
    parameter int KNOT_DEPTH = KVS_DEPTH_DEF,
    parameter int AW         = $clog2(KNOT_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [KNOT_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [KNOT_W-1:0] o_rdata
);

    logic [KNOT_W-1:0] mem [KNOT_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: src/knot_vector_span_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knot_vector_span_engine
// Knot vector store with append, clear, span search and multiplicity count.
// ----------------------------------------------------------------------------
// Request words on i_in carry an action and a signed Q16.16 value; every
// request gives exactly one result word on o_res, in order. Requests are
// taken one at a time; the next one is accepted as soon as the current
// result has moved into the output register, even if the receiver stalls.
// The steps of each request are set by the single read port of the knot
// store, one read per cycle with registered read data:
//   clear            straight to the result
//   append           reads the last knot held, then checks and writes
//   span search      result at once with a bad order, else reads the two
//                    domain knots and ends outside them; at the domain end
//                    reads the last span, else bisects (at most 32 halvings)
//   multiplicity     scans the store one knot per cycle
// A stalled receiver holds the result in the output register and the block
// waits in its result state until the register frees up.
// Tolerance and curve order are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while no request is in flight,
// as the block does not enforce it. Reset empties the knot count and loads
// tolerance 1 and order 4; the store itself is not cleared.
// ----------------------------------------------------------------------------
module knot_vector_span_engine import kvs_pkg::*; #(
    parameter int KNOT_DEPTH = KVS_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    kvs_in_if.sink                     i_in,
    kvs_out_if.source                  o_res
);

    localparam int AW = $clog2(KNOT_DEPTH);
    localparam int CW = $clog2(KNOT_DEPTH + 1);
    localparam int XW = ((CW > ORDER_W) ? CW : ORDER_W) + 1;

    t_state r_state, n_state;

    logic [TOL_W-1:0]          r_tol;
    logic [ORDER_W-1:0]        r_order;
    logic [CW-1:0]             r_count, n_count;
    logic signed [KNOT_W-1:0]  r_v, n_v;
    logic [AW-1:0]             r_addr, n_addr;
    logic [AW-1:0]             r_l, n_l, r_h, n_h, r_m, n_m;
    logic [STEP_W-1:0]         r_steps, n_steps;
    logic                      r_dom_bad, n_dom_bad;
    logic                      r_m_below, n_m_below;
    logic                      r_m_lt, n_m_lt;
    t_status                   r_status, n_status;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [KNOT_W-1:0]         r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0]             r_mult, n_mult;

    logic                      r_ovalid, n_ovalid;
    t_status                   r_o_status, n_o_status;
    logic [POS_W-1:0]          r_o_pos, n_o_pos;
    logic [KNOT_W-1:0]         r_o_lo, n_o_lo, r_o_hi, n_o_hi;
    logic [MULT_W-1:0]         r_o_mult, n_o_mult;
    logic [COUNT_W-1:0]        r_o_count, n_o_count;

    logic                      mem_we;
    logic [KNOT_W-1:0]         rd_data;

    logic signed [CMP_W-1:0]   cmp_v, cmp_k, cmp_t;
    logic                      below_lo, above_hi, ge_hi, v_lt;
    logic [XW-1:0]             n_x, ord_x, first_x, hi_x, last_x;
    logic                      ord_ok;
    logic [AW-1:0]             first_ix, hi_ix, last_ix;
    logic [AW:0]               mid0_sum, mid1_sum;
    logic [AW-1:0]             bis_l, bis_h;
    logic [CW-1:0]             cnt_m1;
    logic                      more;

    kvs_ram #(
        .KNOT_DEPTH (KNOT_DEPTH),
        .AW         (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_v),
        .i_raddr (n_addr),
        .o_rdata (rd_data)
    );

    // tolerance compares on the knot just read, in a range with no overflow
    assign cmp_v    = CMP_W'(r_v);
    assign cmp_k    = CMP_W'($signed(rd_data));
    assign cmp_t    = $signed({{(CMP_W - TOL_W){1'b0}}, r_tol});
    assign below_lo = cmp_v < (cmp_k - cmp_t);
    assign above_hi = cmp_v > (cmp_k + cmp_t);
    assign ge_hi    = cmp_v >= (cmp_k + cmp_t);
    assign v_lt     = cmp_v < cmp_k;

    // span limits: first = order-1, last+1 = count-order
    assign n_x      = XW'(r_count);
    assign ord_x    = XW'(r_order);
    assign ord_ok   = (r_order != '0) && (n_x >= (ord_x << 1));
    assign first_x  = ord_x - XW'(1);
    assign hi_x     = n_x - ord_x;
    assign last_x   = hi_x - XW'(1);
    assign first_ix = first_x[AW-1:0];
    assign hi_ix    = hi_x[AW-1:0];
    assign last_ix  = last_x[AW-1:0];

    assign mid0_sum = {1'b0, first_ix} + {1'b0, last_ix};
    assign bis_l    = r_m_lt ? r_l : r_m;
    assign bis_h    = r_m_lt ? r_m : r_h;
    assign mid1_sum = {1'b0, bis_l} + {1'b0, bis_h};

    assign cnt_m1   = r_count - CW'(1);
    assign more     = (CW'(r_addr) + CW'(1)) < r_count;

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_res.valid        = r_ovalid;
    assign o_res.status       = r_o_status;
    assign o_res.position     = r_o_pos;
    assign o_res.span_low     = r_o_lo;
    assign o_res.span_high    = r_o_hi;
    assign o_res.multiplicity = r_o_mult;
    assign o_res.knot_count   = r_o_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_RESET;
            r_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TOL) begin
                r_tol <= i_cfg_data[TOL_W-1:0];
            end else if (i_cfg_idx == CFG_ORDER) begin
                r_order <= i_cfg_data[ORDER_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_addr     <= n_addr;
        r_l        <= n_l;
        r_h        <= n_h;
        r_m        <= n_m;
        r_steps    <= n_steps;
        r_dom_bad  <= n_dom_bad;
        r_m_below  <= n_m_below;
        r_m_lt     <= n_m_lt;
        r_status   <= n_status;
        r_pos      <= n_pos;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mult     <= n_mult;
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_lo     <= n_o_lo;
        r_o_hi     <= n_o_hi;
        r_o_mult   <= n_o_mult;
        r_o_count  <= n_o_count;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_v        = r_v;
        n_addr     = r_addr;
        n_l        = r_l;
        n_h        = r_h;
        n_m        = r_m;
        n_steps    = r_steps;
        n_dom_bad  = r_dom_bad;
        n_m_below  = r_m_below;
        n_m_lt     = r_m_lt;
        n_status   = r_status;
        n_pos      = r_pos;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mult     = r_mult;
        n_ovalid   = r_ovalid && !o_res.ready;
        n_o_status = r_o_status;
        n_o_pos    = r_o_pos;
        n_o_lo     = r_o_lo;
        n_o_hi     = r_o_hi;
        n_o_mult   = r_o_mult;
        n_o_count  = r_o_count;
        mem_we     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_v      = i_in.value;
                    n_status = STAT_OK;
                    n_pos    = '0;
                    n_lo     = '0;
                    n_hi     = '0;
                    n_mult   = '0;
                    unique case (i_in.action)
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_state = ST_RESP;
                        end
                        ACT_APPEND: begin
                            n_addr  = cnt_m1[AW-1:0];
                            n_state = ST_APPEND;
                        end
                        ACT_SPAN: begin
                            if (!ord_ok) begin
                                n_status = STAT_ORD_INV;
                                n_state  = ST_RESP;
                            end else begin
                                n_addr  = first_ix;
                                n_state = ST_SPAN_LO;
                            end
                        end
                        ACT_MULT: begin
                            n_addr = '0;
                            if (r_count == '0) begin
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_MULT_FIND;
                            end
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_APPEND: begin
                // rd_data is the last knot held
                if ((r_count != '0) && below_lo) begin
                    n_status = STAT_ORDER;
                end else if (r_count >= CW'(KNOT_DEPTH)) begin
                    n_status = STAT_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_pos   = POS_W'(r_count);
                    n_count = r_count + CW'(1);
                end
                n_state = ST_RESP;
            end
            ST_SPAN_LO: begin
                n_dom_bad = below_lo;
                n_addr    = hi_ix;
                n_state   = ST_SPAN_HI;
            end
            ST_SPAN_HI: begin
                if (r_dom_bad || above_hi) begin
                    n_status = STAT_DOMAIN;
                    n_state  = ST_RESP;
                end else if (!below_lo) begin
                    // at the domain end: clamp to the last span
                    n_hi    = rd_data;
                    n_m     = last_ix;
                    n_addr  = last_ix;
                    n_state = ST_SPAN_LAST;
                end else begin
                    n_l     = first_ix;
                    n_h     = last_ix;
                    n_m     = mid0_sum[AW:1];
                    n_addr  = mid0_sum[AW:1];
                    n_steps = '0;
                    n_state = ST_BIS_M;
                end
            end
            ST_SPAN_LAST: begin
                n_lo    = rd_data;
                n_pos   = POS_W'(r_m);
                n_state = ST_RESP;
            end
            ST_BIS_M: begin
                n_m_below = below_lo;
                n_m_lt    = v_lt;
                n_lo      = rd_data;
                n_addr    = r_m + AW'(1);
                n_state   = ST_BIS_M1;
            end
            ST_BIS_M1: begin
                if ((r_m_below || ge_hi) && (r_steps < STEP_W'(SEARCH_LIMIT))) begin
                    n_l     = bis_l;
                    n_h     = bis_h;
                    n_m     = mid1_sum[AW:1];
                    n_addr  = mid1_sum[AW:1];
                    n_steps = r_steps + STEP_W'(1);
                    n_state = ST_BIS_M;
                end else begin
                    n_hi    = rd_data;
                    n_pos   = POS_W'(r_m);
                    n_state = ST_RESP;
                end
            end
            ST_MULT_FIND: begin
                n_addr = r_addr + AW'(1);
                if (!below_lo && !above_hi) begin
                    n_mult  = CW'(1);
                    n_state = more ? ST_MULT_RUN : ST_RESP;
                end else if (!more) begin
                    n_state = ST_RESP;
                end
            end
            ST_MULT_RUN: begin
                // run of knots no more than tolerance above the value
                n_addr = r_addr + AW'(1);
                if (!below_lo) begin
                    n_mult = r_mult + CW'(1);
                    if (!more) begin
                        n_state = ST_RESP;
                    end
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_pos    = r_pos;
                    n_o_lo     = r_lo;
                    n_o_hi     = r_hi;
                    n_o_mult   = MULT_W'(r_mult);
                    n_o_count  = COUNT_W'(r_count);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the knot vector span engine.
// ----------------------------------------------------------------------------
// A queue of request words is filled phase by phase: a short directed knot
// vector first, then random knot vectors with searches and multiplicity
// lookups around them. A clocked driver presents the words and a clocked
// monitor takes the results. A predictor written from the block's spec
// follows every accepted request and its answer is compared field by field
// with each result word. Tolerance and curve order change between phases
// while the block is idle. The phases cycle through no idling, a slow
// sender, a stalling receiver and both at once.
// ----------------------------------------------------------------------------
module tb_top import kvs_pkg::*; ();

    localparam int     STORE_DEPTH  = 256;
    localparam int     BISECT_LIMIT = 32;
    localparam int     PHASES       = 12;
    localparam int     PHASE_ITEMS  = 70;
    localparam int     DRAIN_CYCLES = 600;
    localparam int     LIMIT_CYCLES = 2_000_000;
    localparam int     MAX_REPORTS  = 200;
    localparam longint KNOT_MIN     = -64'sd2147483648;
    localparam longint KNOT_MAX     = 64'sd2147483647;

    typedef struct {
        t_action                  action;
        logic signed [KNOT_W-1:0] value;
    } t_knot_request;

    typedef struct {
        t_status                  status;
        logic [POS_W-1:0]         position;
        logic signed [KNOT_W-1:0] span_low;
        logic signed [KNOT_W-1:0] span_high;
        logic [MULT_W-1:0]        multiplicity;
        logic [COUNT_W-1:0]       knot_count;
    } t_knot_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    kvs_in_if  req_if ();
    kvs_out_if res_if ();

    knot_vector_span_engine #(
        .KNOT_DEPTH (STORE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (req_if),
        .o_res      (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic signed [KNOT_W-1:0] model_knots [STORE_DEPTH];
    int     model_count;
    longint model_tol;
    longint model_order;

    t_knot_request pending_requests [$];
    t_knot_result  expected_words [$];
    longint        gen_knots [$];

    int  error_count;
    int  accepted_count;
    int  checked_count;
    int  stim_count;
    int  mult_hits;
    int  status_tally [5];
    int  src_idle_pct;
    int  snk_stall_pct;
    int  cycle_count;

    function automatic longint knot_at(input longint idx);
        if (idx < 0 || idx >= STORE_DEPTH) return 0;
        return longint'(model_knots[idx]);
    endfunction

    function automatic t_knot_result predict_result(
        input t_action act,
        input logic signed [KNOT_W-1:0] value
    );
        t_knot_result r;
        longint v, n, first, last, span, lo_i, hi_i, mid, f, e, i, d;
        int steps;
        r.status       = STAT_OK;
        r.position     = '0;
        r.span_low     = '0;
        r.span_high    = '0;
        r.multiplicity = '0;
        v = longint'(value);
        n = longint'(model_count);
        case (act)
            ACT_CLEAR: begin
                model_count = 0;
            end
            ACT_APPEND: begin
                // order check wins over the full check
                if (n > 0 && v < knot_at(n - 1) - model_tol) begin
                    r.status = STAT_ORDER;
                end else if (n >= STORE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    model_knots[n] = value;
                    r.position     = 8'(n);
                    model_count    = int'(n + 1);
                end
            end
            ACT_SPAN: begin
                first = model_order - 1;
                last  = n - model_order - 1;
                if (model_order < 1 || last < first) begin
                    r.status = STAT_ORD_INV;
                end else if (v < knot_at(first) - model_tol ||
                             v > knot_at(last + 1) + model_tol) begin
                    r.status = STAT_DOMAIN;
                end else begin
                    // near the upper domain knot the last span is taken
                    span = last;
                    if (v < knot_at(last + 1) - model_tol) begin
                        lo_i  = first;
                        hi_i  = last;
                        mid   = (first + last) / 2;
                        steps = 0;
                        while ((v < knot_at(mid) - model_tol ||
                                v >= knot_at(mid + 1) + model_tol) &&
                               steps < BISECT_LIMIT) begin
                            if (v < knot_at(mid)) hi_i = mid;
                            else lo_i = mid;
                            mid = (lo_i + hi_i) / 2;
                            steps++;
                        end
                        span = mid;
                    end
                    r.position  = 8'(span);
                    r.span_low  = 32'(knot_at(span));
                    r.span_high = 32'(knot_at(span + 1));
                end
            end
            default: begin
                f = -1;
                for (i = 0; i < n && f < 0; i++) begin
                    d = knot_at(i) - v;
                    if (d <= model_tol && -d <= model_tol) f = i;
                end
                if (f >= 0) begin
                    e = f;
                    while (e + 1 < n && knot_at(e + 1) - v <= model_tol) e++;
                    r.multiplicity = 9'(e - f + 1);
                    mult_hits++;
                end
            end
        endcase
        r.knot_count = 9'(model_count);
        status_tally[int'(r.status)]++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    int src_quiet;

    always @(posedge i_clk) begin : drive_requests
        t_knot_request next_req;
        bit            gap;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_words.push_back(predict_result(req_if.action, req_if.value));
                accepted_count++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (src_quiet > 0) src_quiet--;
                else if ($urandom_range(0, 199) == 0) src_quiet = $urandom_range(16, 96);
                gap = (src_quiet == 0) && ($urandom_range(0, 99) < src_idle_pct);
                if (pending_requests.size() != 0 && !gap) begin
                    next_req = pending_requests.pop_front();
                    req_if.valid  <= 1'b1;
                    req_if.action <= next_req.action;
                    req_if.value  <= next_req.value;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    int snk_quiet;

    task automatic flag_field(input string fname, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h",
                         $time, fname, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : take_results
        t_knot_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_words.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result word, expected none, got status %0d",
                             $time, res_if.status);
            end else begin
                want = expected_words.pop_front();
                checked_count++;
                flag_field("status", {29'd0, want.status}, {29'd0, res_if.status});
                flag_field("position", {24'd0, want.position}, {24'd0, res_if.position});
                flag_field("span_low", want.span_low, res_if.span_low);
                flag_field("span_high", want.span_high, res_if.span_high);
                flag_field("multiplicity", {23'd0, want.multiplicity},
                           {23'd0, res_if.multiplicity});
                flag_field("knot_count", {23'd0, want.knot_count}, {23'd0, res_if.knot_count});
            end
        end
        if (snk_quiet > 0) snk_quiet--;
        else if ($urandom_range(0, 199) == 0) snk_quiet = $urandom_range(16, 96);
        res_if.ready <= !((snk_quiet == 0) && ($urandom_range(0, 99) < snk_stall_pct));
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("knot_vector_span_engine regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic longint clamp_knot(input longint x);
        if (x > KNOT_MAX) return KNOT_MAX;
        if (x < KNOT_MIN) return KNOT_MIN;
        return x;
    endfunction

    function automatic longint rand_word();
        logic signed [KNOT_W-1:0] w;
        w = $urandom;
        return longint'(w);
    endfunction

    task automatic push_item(input t_action act, input longint v);
        t_knot_request item;
        item.action = act;
        item.value  = 32'(v);
        pending_requests.push_back(item);
        stim_count++;
    endtask

    // keeps the generator's picture of the store in step with the block
    task automatic queue_append(input longint v);
        push_item(ACT_APPEND, v);
        if ((gen_knots.size() == 0 || v >= gen_knots[$] - model_tol) &&
            gen_knots.size() < STORE_DEPTH)
            gen_knots.push_back(v);
    endtask

    function automatic longint pick_near_knot();
        longint base;
        if (gen_knots.size() == 0) return rand_word();
        base = gen_knots[$urandom_range(0, gen_knots.size() - 1)];
        return clamp_knot(base + longint'($urandom_range(0, 32'(2 * model_tol + 2)))
                          - (model_tol + 1));
    endfunction

    function automatic longint pick_parameter();
        int     n, r, i;
        longint diff, base;
        n = gen_knots.size();
        r = $urandom_range(0, 99);
        if (n < 2 || r >= 88) return rand_word();
        if (r < 40) begin
            i    = $urandom_range(0, n - 2);
            diff = gen_knots[i + 1] - gen_knots[i];
            if (diff <= 0) return gen_knots[i];
            return gen_knots[i] + longint'($urandom) % (diff + 1);
        end
        if (r < 65 || model_order < 1 || n < 2 * model_order) return pick_near_knot();
        // around the ends of the domain
        base = (r < 76) ? gen_knots[model_order - 1] : gen_knots[n - model_order];
        return clamp_knot(base + longint'($urandom_range(0, 32'(2 * model_tol + 4)))
                          - (model_tol + 2));
    endfunction

    task automatic build_sequence(input int n_knots, input bit overfill);
        longint cur, step;
        int     r, q;
        t_action act;
        push_item(ACT_CLEAR, rand_word());
        gen_knots.delete();
        r = $urandom_range(0, 99);
        if (r < 65) cur = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        else if (r < 80) cur = KNOT_MIN + $urandom_range(0, 65535);
        else if (r < 90) cur = KNOT_MAX - $urandom_range(0, 1 << 20);
        else cur = rand_word();
        while (gen_knots.size() < n_knots) begin
            r = $urandom_range(0, 99);
            if (r < 6 && gen_knots.size() > 0 &&
                gen_knots[$] - model_tol - 1 >= KNOT_MIN) begin
                // a knot that breaks the order, turned away
                queue_append(clamp_knot(gen_knots[$] - model_tol - 1
                                        - $urandom_range(0, 255)));
            end else begin
                if (r < 25) step = 0;
                else if (r < 35) step = -longint'($urandom_range(0, 32'(model_tol)));
                else if (r < 85) step = $urandom_range(1, 131072);
                else step = $urandom_range(1, 1 << 27);
                cur = clamp_knot(cur + step);
                queue_append(cur);
            end
        end
        if (overfill) begin
            queue_append(cur);
            queue_append(cur);
            queue_append(KNOT_MIN);
        end
        q = $urandom_range(4, 14);
        repeat (q) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                push_item(ACT_SPAN, pick_parameter());
            end else if (r < 85) begin
                push_item(ACT_MULT,
                          ($urandom_range(0, 4) == 0) ? rand_word() : pick_near_knot());
            end else if (r < 92) begin
                cur = clamp_knot(cur + $urandom_range(0, 65536));
                queue_append(cur);
            end else if (r < 97) begin
                act = t_action'($urandom_range(0, 3));
                if (act == ACT_APPEND) begin
                    queue_append(rand_word());
                end else begin
                    push_item(act, rand_word());
                    if (act == ACT_CLEAR) gen_knots.delete();
                end
            end else begin
                push_item(ACT_CLEAR, rand_word());
                gen_knots.delete();
            end
        end
    endtask

    task automatic run_phase(input int budget);
        int target, cap;
        target = stim_count + budget;
        while (stim_count < target) begin
            cap = 2 * int'(model_order) + 12;
            if (cap > 40) cap = 40;
            build_sequence($urandom_range(0, cap), 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_words.size() != 0 || req_if.valid)
            @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg idx, input int unsigned data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= 16'(data);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TOL) model_tol = longint'(data & 32'hFFFF);
        else model_order = longint'(data & 32'h1FF);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
            1: begin src_idle_pct <= 72; snk_stall_pct <= 0;  end
            2: begin src_idle_pct <= 0;  snk_stall_pct <= 72; end
            default: begin src_idle_pct <= 24; snk_stall_pct <= 24; end
        endcase
    endtask

    initial begin
        int phase;
        req_if.valid  = 1'b0;
        req_if.action = ACT_CLEAR;
        req_if.value  = '0;
        res_if.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_TOL;
        cfg_data      = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        model_count   = 0;
        model_tol     = 1;
        model_order   = 4;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed knot vector under reset tolerance and order
        push_item(ACT_SPAN, 0);
        push_item(ACT_MULT, 0);
        queue_append(KNOT_MIN);
        repeat (3) queue_append(-196608);
        queue_append(0);
        queue_append(65535);
        queue_append(65534);          // slightly decreasing, inside tolerance
        queue_append(131072);
        queue_append(131072);
        queue_append(KNOT_MAX);
        queue_append(0);              // out of order
        push_item(ACT_SPAN, KNOT_MIN);
        push_item(ACT_SPAN, KNOT_MAX);
        push_item(ACT_SPAN, 65535);   // at the domain end
        push_item(ACT_SPAN, -196608);
        push_item(ACT_SPAN, 65000);
        push_item(ACT_MULT, -196608);
        push_item(ACT_MULT, KNOT_MAX);
        push_item(ACT_MULT, 32'sh4000_0000);
        push_item(ACT_CLEAR, -1);
        queue_append(KNOT_MAX);
        queue_append(KNOT_MAX);
        push_item(ACT_MULT, KNOT_MAX);
        gen_knots.delete();
        push_item(ACT_CLEAR, KNOT_MAX);

        set_idling(0);
        run_phase(60);
        for (phase = 1; phase < PHASES; phase++) begin
            wait_drained();
            repeat (4) @(posedge i_clk);
            case (phase)
                1: begin write_register(CFG_TOL, 0);     write_register(CFG_ORDER, 1); end
                2: begin write_register(CFG_TOL, 65535); write_register(CFG_ORDER, 4); end
                3: begin
                    write_register(CFG_TOL, $urandom_range(0, 255));
                    write_register(CFG_ORDER, 3);
                end
                4: begin write_register(CFG_TOL, 2);     write_register(CFG_ORDER, 0); end
                5: begin
                    write_register(CFG_TOL, $urandom_range(0, 15));
                    write_register(CFG_ORDER, 128);
                end
                6: begin write_register(CFG_TOL, 0);     write_register(CFG_ORDER, 256); end
                7: begin
                    write_register(CFG_TOL, $urandom_range(0, 65535));
                    write_register(CFG_ORDER, $urandom_range(1, 8));
                end
                default: begin
                    write_register(CFG_TOL, ($urandom_range(0, 1) != 0) ?
                                   $urandom_range(0, 3) : $urandom_range(0, 1024));
                    write_register(CFG_ORDER, $urandom_range(1, 6));
                end
            endcase
            set_idling(phase % 4);
            // a full store with the largest order that still fits
            if (phase == 5) build_sequence(STORE_DEPTH, 1'b1);
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests over %0d phases, %0d results checked",
                 accepted_count, PHASES, checked_count);
        $display("ok %0d, out of order %0d, full %0d, bad order %0d, outside %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        $display("multiplicity hits %0d", mult_hits);
        if (error_count == 0) begin
            $display("knot_vector_span_engine regression: pass");
        end else begin
            $display("knot_vector_span_engine regression: fail");
        end
        $finish;
    end

endmodule
